### rtl/swg_pkg.sv
// Shared constants and widths for the SwiGLU activation pipeline.
package swg_pkg;

	localparam int QF = 28;

	localparam int IN_W  = 24;
	localparam int A_W   = 34;
	localparam int T_W   = 64;
	localparam int N_W   = 5;
	localparam int R_W   = 30;
	localparam int P_W   = 31;
	localparam int M_W   = R_W + P_W;
	localparam int E_W   = 45;
	localparam int D_W   = 46;
	localparam int S_W   = 17;
	localparam int XY_W  = 2 * IN_W;
	localparam int PR_W  = XY_W + S_W + 1;

	localparam int EXP_LAT = 10;
	localparam int DIV_LAT = S_W + 1;

	localparam logic signed [R_W-1:0] LOG2E_Q = R_W'(387270501);
	localparam logic signed [A_W-1:0] LN2_Q   = A_W'(186065280);
	localparam logic signed [P_W-1:0] C5_Q    = P_W'(2236961);
	localparam logic signed [P_W-1:0] C4_Q    = P_W'(11184812);
	localparam logic signed [P_W-1:0] C3_Q    = P_W'(44739244);
	localparam logic signed [P_W-1:0] C2_Q    = P_W'(134217728);
	localparam logic signed [P_W-1:0] ONE_Q   = P_W'(268435456);

	localparam logic signed [IN_W-1:0] MAX_OUT = 24'sh7FFFFF;
	localparam logic signed [IN_W-1:0] MIN_OUT = 24'sh800000;

endpackage

### rtl/swg_exp.sv
// Pipelined fixed-point exp(-x) with clamp, ln2 range reduction and Horner polynomial.
module swg_exp import swg_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic signed [IN_W-1:0] x,
	output logic        [E_W-1:0]  e
);

	localparam logic signed [A_W-1:0] LIM = A_W'(10 << FRAC_BITS);
	localparam logic signed [T_W-1:0] HALF = T_W'(1) <<< (2 * QF - 1);

	logic signed [A_W-1:0] xw, neg, clamped;
	logic signed [A_W-1:0] a_s1, a_s2;
	logic signed [T_W-1:0] t_c, t_s2, rnd;
	logic signed [N_W-1:0] n_c;
	logic signed [A_W-1:0] nl, r_c;
	logic signed [R_W-1:0] r_s3;
	logic signed [N_W-1:0] n_s3;
	logic signed [M_W-1:0] m_s [0:4];
	logic signed [R_W-1:0] r_s [0:3];
	logic signed [N_W-1:0] n_s [0:4];
	logic signed [P_W-1:0] p_c [1:4];
	logic signed [P_W-1:0] hc  [1:4];
	logic signed [M_W-1:0] sh9;
	logic signed [P_W-1:0] p_s9;
	logic signed [N_W-1:0] n_s9, n_neg;
	logic        [E_W-1:0] pu;

	assign hc[1] = C4_Q;
	assign hc[2] = C3_Q;
	assign hc[3] = C2_Q;
	assign hc[4] = ONE_Q;

	// clamp -x to the +/-10 window, then move it to Q28
	always_comb begin
		xw = A_W'(x);
		neg = -xw;
		if (neg > LIM) begin
			clamped = LIM;
		end else if (neg < -LIM) begin
			clamped = -LIM;
		end else begin
			clamped = neg;
		end
	end

	assign t_c = T_W'(a_s1) * T_W'(LOG2E_Q);

	always_comb begin
		rnd = t_s2 + HALF;
		n_c = rnd[2*QF+N_W-1:2*QF];
		nl  = A_W'(n_c) * LN2_Q;
		r_c = a_s2 - nl;
	end

	for (genvar k = 1; k <= 4; k++) begin : g_horner
		logic signed [M_W-1:0] sh;
		assign sh = m_s[k-1] >>> QF;
		assign p_c[k] = hc[k] + sh[P_W-1:0];
	end

	assign sh9 = m_s[4] >>> QF;

	always_comb begin
		n_neg = -n_s9;
		pu = E_W'(p_s9[P_W-2:0]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= clamped <<< (QF - FRAC_BITS);
			t_s2 <= t_c;
			a_s2 <= a_s1;
			r_s3 <= r_c[R_W-1:0];
			n_s3 <= n_c;
			m_s[0] <= M_W'(r_s3) * M_W'(C5_Q);
			r_s[0] <= r_s3;
			n_s[0] <= n_s3;
			for (int k = 1; k <= 4; k++) begin
				m_s[k] <= M_W'(r_s[k-1]) * M_W'(p_c[k]);
				n_s[k] <= n_s[k-1];
			end
			for (int k = 1; k <= 3; k++) begin
				r_s[k] <= r_s[k-1];
			end
			p_s9 <= ONE_Q + sh9[P_W-1:0];
			n_s9 <= n_s[4];
			if (n_s9 >= 0) begin
				e <= pu << n_s9[N_W-2:0];
			end else begin
				e <= pu >> n_neg[N_W-2:0];
			end
		end
	end

endmodule

### rtl/swg_recip.sv
// Pipelined restoring divider: rounded 2^44 / (2^28 + e), one quotient bit per stage.
module swg_recip import swg_pkg::*; (
	input  logic           clk,
	input  logic           en,
	input  logic [E_W-1:0] e,
	output logic [S_W-1:0] s
);

	logic [D_W-1:0] den_c, num_c;
	logic [D_W-1:0] rem_s [0:S_W-1];
	logic [D_W-1:0] den_s [0:S_W-1];
	logic [S_W-1:0] nlo_s [0:S_W-1];
	logic [S_W-1:0] quo_s [0:S_W];
	logic [D_W:0]   trial [1:S_W];
	logic           ge    [1:S_W];

	always_comb begin
		den_c = D_W'(e) + D_W'(ONE_Q);
		num_c = (D_W'(1) << 44) + (den_c >> 1);
	end

	for (genvar k = 1; k <= S_W; k++) begin : g_step
		assign trial[k] = {rem_s[k-1], nlo_s[k-1][S_W-k]};
		assign ge[k] = trial[k] >= {1'b0, den_s[k-1]};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num_c >> S_W;
			nlo_s[0] <= num_c[S_W-1:0];
			den_s[0] <= den_c;
			quo_s[0] <= '0;
			for (int k = 1; k < S_W; k++) begin
				if (ge[k]) begin
					rem_s[k] <= D_W'(trial[k] - {1'b0, den_s[k-1]});
				end else begin
					rem_s[k] <= trial[k][D_W-1:0];
				end
				nlo_s[k] <= nlo_s[k-1];
				den_s[k] <= den_s[k-1];
			end
			for (int k = 1; k <= S_W; k++) begin
				quo_s[k] <= {quo_s[k-1][S_W-2:0], ge[k]};
			end
		end
	end

	assign s = quo_s[S_W];

endmodule

### rtl/swiglu_activation.sv
// Top level of the SwiGLU activation: x * y * sigmoid(x) in a streaming pipeline.
//
// Each request carries a gate value x, an up value y and a last-element marker; the block
// returns x*y*sigmoid(x) in the same signed fixed-point format, rounded and saturated, with
// a saturation flag and the marker copied through. The pipeline is 30 stages deep: ten for
// exp(-x) (clamp, ln2 reduction, five Horner multiplies, scale by 2^n), eighteen for the
// reciprocal divider (one quotient bit per stage), one for the final multiply and one output
// register. It takes one request per cycle and gives one result per cycle. The whole pipe
// advances together: when the output register holds a result that is not taken, every
// stage holds and in_ready drops.
module swiglu_activation import swg_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic signed [IN_W-1:0] gate_value,
	input  logic signed [IN_W-1:0] up_value,
	input  logic                   in_last,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic signed [IN_W-1:0] product,
	output logic                   saturated,
	output logic                   out_last
);

	localparam int LAT    = EXP_LAT + DIV_LAT + 2;
	localparam int XY_LAT = EXP_LAT + DIV_LAT;
	localparam int SH     = FRAC_BITS + 16;
	localparam int Q_W    = PR_W + 1;

	logic                   en;
	logic                   vld_q [0:LAT-1];
	logic                   last_s [0:LAT-1];
	logic signed [XY_W-1:0] xy_s [0:XY_LAT-1];
	logic        [E_W-1:0]  e_val;
	logic        [S_W-1:0]  s_val;
	logic signed [PR_W-1:0] prod_s;
	logic signed [Q_W-1:0]  sum_c, q_c;

	// advance everything unless a finished result is stuck at the output
	assign en       = !vld_q[LAT-1] || out_ready;
	assign in_ready = en;
	assign out_valid = vld_q[LAT-1];
	assign out_last  = last_s[LAT-1];

	swg_exp #(
		.FRAC_BITS(FRAC_BITS)
	) u_exp (
		.clk(clk),
		.en (en),
		.x  (gate_value),
		.e  (e_val)
	);

	swg_recip u_recip (
		.clk(clk),
		.en (en),
		.e  (e_val),
		.s  (s_val)
	);

	// round half up, then drop the Q16 sigmoid and input fraction bits
	always_comb begin
		sum_c = Q_W'(prod_s) + (Q_W'(1) <<< (SH - 1));
		q_c   = sum_c >>> SH;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LAT; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else if (en) begin
			vld_q[0] <= in_valid;
			for (int i = 1; i < LAT; i++) begin
				vld_q[i] <= vld_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xy_s[0]   <= XY_W'(gate_value) * XY_W'(up_value);
			last_s[0] <= in_last;
			for (int i = 1; i < XY_LAT; i++) begin
				xy_s[i] <= xy_s[i-1];
			end
			for (int i = 1; i < LAT; i++) begin
				last_s[i] <= last_s[i-1];
			end
			prod_s <= PR_W'(xy_s[XY_LAT-1]) * PR_W'($signed({1'b0, s_val}));
			// clip to the 24-bit range and flag it
			if (q_c > Q_W'(MAX_OUT)) begin
				product   <= MAX_OUT;
				saturated <= 1'b1;
			end else if (q_c < Q_W'(MIN_OUT)) begin
				product   <= MIN_OUT;
				saturated <= 1'b1;
			end else begin
				product   <= q_c[IN_W-1:0];
				saturated <= 1'b0;
			end
		end
	end

	a_accept_enters : assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_q[0])
		else $error("accepted request did not enter the pipe");

	a_sat_clipped : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> product == MAX_OUT || product == MIN_OUT)
		else $error("saturated result not at a range limit");

	a_sigmoid_range : assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[XY_LAT-1] |-> s_val <= S_W'(65536))
		else $error("sigmoid above one");

endmodule
